[rtl/core/square_mod_string_hash64_unit_assert.svh]
// ----------------------------------------------------------------------------
// square_mod_string_hash64_unit assertion macros
// Shared assertion forms for the hash unit checker, clocked on clk and
// quiet while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SQUARE_MOD_STRING_HASH64_UNIT_ASSERT_SVH
`define SQUARE_MOD_STRING_HASH64_UNIT_ASSERT_SVH

// Property checked on every rising clk edge outside of reset.
`define SMH64_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");

// Same check, with a message of its own.
`define SMH64_ASSERT_MSG(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

`endif

[rtl/core/smh64_pkg.sv]
// ----------------------------------------------------------------------------
// smh64_pkg
// Widths and constants shared by the square-mod string hash unit.
// ----------------------------------------------------------------------------
`default_nettype none

package smh64_pkg;

    // Field and state widths.
    localparam int unsigned HashWidth   = 64;
    localparam int unsigned ByteWidth   = 8;
    localparam int unsigned SquareWidth = 15;
    localparam int unsigned LowWidth    = 56;

    // Bit positions used when folding a request into the state.
    localparam int unsigned HashShift   = 8;
    localparam int unsigned ParityShift = 48;

    // Modulus 2^56 - 3, one bit wider than the low part so sums compare directly.
    localparam logic [LowWidth:0] HashModulus = 57'h00fffffffffffffd;

    typedef logic [HashWidth-1:0]   hash_t;
    typedef logic [SquareWidth-1:0] square_t;

endpackage

`default_nettype wire

[rtl/core/smh64_reduce.sv]
// ----------------------------------------------------------------------------
// smh64_reduce
// Shifts the running remainder by one byte, merges in the new square and
// reduces the result by truncated signed remainder modulo 2^56 - 3.
// ----------------------------------------------------------------------------
`default_nettype none

module smh64_reduce
(
    input  wire smh64_pkg::hash_t   acc,
    input  wire smh64_pkg::square_t square,
    output smh64_pkg::hash_t        acc_next
);

    smh64_pkg::hash_t                  dividend;
    logic                              negative;
    smh64_pkg::hash_t                  magnitude;
    logic [7:0]                        high_part;
    logic [smh64_pkg::LowWidth:0]      folded;
    logic [smh64_pkg::LowWidth:0]      reduced;
    smh64_pkg::hash_t                  reduced_wide;

    // Shift left by one byte (upper bits fall off) and OR in the square.
    assign dividend = {acc[smh64_pkg::HashWidth-smh64_pkg::HashShift-1:0],
                       smh64_pkg::HashShift'(0)}
                    | {{(smh64_pkg::HashWidth-smh64_pkg::SquareWidth){1'b0}}, square};

    // The remainder takes the sign of the dividend, so reduce the magnitude.
    assign negative  = dividend[smh64_pkg::HashWidth-1];
    assign magnitude = negative ? (smh64_pkg::hash_t'(0) - dividend) : dividend;

    // Since 2^56 is 3 modulo the modulus, the top byte folds in times three.
    assign high_part = magnitude[smh64_pkg::HashWidth-1:smh64_pkg::LowWidth];
    assign folded    = {1'b0, magnitude[smh64_pkg::LowWidth-1:0]}
                     + {{(smh64_pkg::LowWidth-8){1'b0}}, high_part, 1'b0}
                     + {{(smh64_pkg::LowWidth-7){1'b0}}, high_part};

    // The folded value is below twice the modulus: one conditional subtract.
    assign reduced = (folded >= smh64_pkg::HashModulus)
                   ? (folded - smh64_pkg::HashModulus) : folded;

    // Restore the sign.
    assign reduced_wide = {{(smh64_pkg::HashWidth-smh64_pkg::LowWidth){1'b0}},
                           reduced[smh64_pkg::LowWidth-1:0]};
    assign acc_next = negative ? (smh64_pkg::hash_t'(0) - reduced_wide) : reduced_wide;

endmodule

`default_nettype wire

[rtl/core/square_mod_string_hash64_unit.sv]
// ----------------------------------------------------------------------------
// square_mod_string_hash64_unit
// Streaming 64-bit string hash: one byte per request, last byte flagged,
// one hash result per string.
// ----------------------------------------------------------------------------
// The unit takes one byte per clock cycle while in_stall is low and presents
// the hash on out_valid from the result register once the last byte of a
// string has passed through the input register. A byte is squared on its
// way into the input register; from there it is folded into the square sum,
// the parity word and the remainder, whose shift-and-reduce step is
// combinational, and this loop on the remainder register sets the
// rate of one byte per cycle. A finished hash waits in the result register
// while the following string streams in; in_stall rises only while a last
// byte is held behind a result that is still stalled. State clears itself
// after each string.
// ----------------------------------------------------------------------------
`default_nettype none

module square_mod_string_hash64_unit
(
    input  wire                     clk,
    input  wire                     rst_n,
    // Byte requests.
    input  wire                     in_valid,
    output logic                    in_stall,
    input  wire [7:0]               byte_in,
    input  wire                     is_last,
    // Hash results.
    output logic                    out_valid,
    input  wire                     out_stall,
    output smh64_pkg::hash_t        hash_value
);

    // Input register.
    logic                  s1_valid_reg, s1_valid_next;
    smh64_pkg::square_t    s1_square_reg, s1_square_next;
    logic                  s1_last_reg, s1_last_next;

    // Running string state.
    smh64_pkg::hash_t      rem_reg, rem_next;
    smh64_pkg::hash_t      sum_reg, sum_next;
    smh64_pkg::square_t    par_reg, par_next;

    // Result register.
    logic                  out_valid_reg, out_valid_next;
    smh64_pkg::hash_t      out_rem_reg, out_rem_next;
    smh64_pkg::hash_t      out_sum_reg, out_sum_next;
    smh64_pkg::square_t    out_par_reg, out_par_next;

    logic [7:0]            byte_mag;
    smh64_pkg::square_t    byte_prod;
    logic                  advance;
    smh64_pkg::hash_t      rem_fold;
    smh64_pkg::hash_t      sum_fold;
    smh64_pkg::square_t    par_fold;

    // Square of the byte read as signed; the magnitude of -128 is 128.
    assign byte_mag  = byte_in[7] ? (8'd0 - byte_in) : byte_in;
    assign byte_prod = {{(smh64_pkg::SquareWidth-smh64_pkg::ByteWidth){1'b0}}, byte_mag}
                     * {{(smh64_pkg::SquareWidth-smh64_pkg::ByteWidth){1'b0}}, byte_mag};

    // A last byte waits only while the result register is full and stalled.
    assign in_stall = s1_valid_reg && s1_last_reg && out_valid_reg && out_stall;
    assign advance  = s1_valid_reg && !in_stall;

    // Fold the registered square into the running state.
    smh64_reduce u_reduce
    (
        .acc      (rem_reg),
        .square   (s1_square_reg),
        .acc_next (rem_fold)
    );

    assign sum_fold = sum_reg + {{(smh64_pkg::HashWidth-smh64_pkg::SquareWidth){1'b0}},
                                 s1_square_reg};
    assign par_fold = par_reg ^ s1_square_reg;

    // Input register next values.
    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        s1_square_next = s1_square_reg;
        s1_last_next   = s1_last_reg;
        if (!in_stall)
        begin
            s1_valid_next  = in_valid;
            s1_square_next = byte_prod;
            s1_last_next   = is_last;
        end
    end

    // State and result next values.
    always_comb
    begin
        rem_next       = rem_reg;
        sum_next       = sum_reg;
        par_next       = par_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_rem_next   = out_rem_reg;
        out_sum_next   = out_sum_reg;
        out_par_next   = out_par_reg;
        if (advance)
        begin
            if (s1_last_reg)
            begin
                // Hand the finished string to the result register and clear.
                rem_next       = '0;
                sum_next       = '0;
                par_next       = '0;
                out_valid_next = 1'b1;
                out_rem_next   = rem_fold;
                out_sum_next   = sum_fold;
                out_par_next   = par_fold;
            end
            else
            begin
                rem_next = rem_fold;
                sum_next = sum_fold;
                par_next = par_fold;
            end
        end
    end

    // Control and string state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            rem_reg       <= '0;
            sum_reg       <= '0;
            par_reg       <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            rem_reg       <= rem_next;
            sum_reg       <= sum_next;
            par_reg       <= par_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        s1_square_reg <= s1_square_next;
        s1_last_reg   <= s1_last_next;
        out_rem_reg   <= out_rem_next;
        out_sum_reg   <= out_sum_next;
        out_par_reg   <= out_par_next;
    end

    // Final combine from the held result.
    assign out_valid  = out_valid_reg;
    assign hash_value = (out_rem_reg
                        | {{(smh64_pkg::HashWidth-smh64_pkg::ParityShift
                             -smh64_pkg::SquareWidth){1'b0}},
                           out_par_reg, smh64_pkg::ParityShift'(0)})
                      + out_sum_reg;

endmodule

`default_nettype wire

[rtl/core/smh64_check.sv]
// ----------------------------------------------------------------------------
// smh64_check
// Port-level checks on the hash unit's request and result channels,
// bound to every instance of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "square_mod_string_hash64_unit_assert.svh"

module smh64_check
(
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     in_valid,
    input  wire                     in_stall,
    input  wire [7:0]               byte_in,
    input  wire                     is_last,
    input  wire                     out_valid,
    input  wire                     out_stall,
    input  wire smh64_pkg::hash_t   hash_value
);

    logic last_taken;

    // A last byte accepted on this edge.
    assign last_taken = in_valid && !in_stall && is_last;

    // A stalled request stays offered and unchanged.
    `SMH64_ASSERT(a_in_hold, in_valid && in_stall |=> in_valid && $stable({byte_in, is_last}))

    // A stalled result stays offered and unchanged.
    `SMH64_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(hash_value))

    // The request side stalls only behind a full, stalled result register.
    `SMH64_ASSERT_MSG(a_stall_cause, in_stall |-> out_valid && out_stall, "stray input stall")

    // A fresh result follows an accepted last byte by way of the input register.
    `SMH64_ASSERT(a_result_source, $rose(out_valid) |-> $past(last_taken, 2))

endmodule

bind square_mod_string_hash64_unit smh64_check u_smh64_check
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .byte_in    (byte_in),
    .is_last    (is_last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hash_value (hash_value)
);

`default_nettype wire

[bench/square_mod_string_hash64_unit_tb.sv]
// ----------------------------------------------------------------------------
// square_mod_string_hash64_unit_tb
// Self-checking bench for the streaming string hash unit. Strings are fed one
// byte per request. A cycle-free predictor folds each accepted byte into its
// own sum, parity and signed remainder, and queues the hash due on every last
// byte. Each returned hash is checked against the oldest queued value. The
// run goes through phases with random sender gaps and receiver stalls, and
// one long receiver hold-off.
// ----------------------------------------------------------------------------
module square_mod_string_hash64_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // Idling schemes applied to both sides of the block.
    typedef enum logic [1:0] {
        PH_STEADY,
        PH_SENDER_GAPS,
        PH_RECEIVER_STALLS,
        PH_BOTH_IDLE
    } link_phase_t;

    typedef struct {
        logic [7:0]  data;
        logic        last;
        link_phase_t phase;
    } byte_req_t;

    localparam int unsigned HoldCycles = 80;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [7:0]          byte_in;
    logic                is_last;
    logic                out_valid;
    logic                out_stall;
    smh64_pkg::hash_t    hash_value;

    // Pending byte requests and hashes still owed by the block.
    byte_req_t           pending_bytes[$];
    smh64_pkg::hash_t    hash_expect[$];
    byte_req_t           next_req;
    link_phase_t         link_phase;

    // Predictor state, mirrors the block's accumulators.
    smh64_pkg::hash_t    pred_remainder;
    smh64_pkg::hash_t    pred_sum;
    smh64_pkg::square_t  pred_parity;

    int unsigned bytes_taken;
    int unsigned strings_queued;
    int unsigned hashes_checked;
    int unsigned mismatch_count;
    int unsigned hold_left;
    logic        hold_done;

    square_mod_string_hash64_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .byte_in    (byte_in),
        .is_last    (is_last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .hash_value (hash_value)
    );

    // Square of a byte read as a signed 8-bit value.
    function automatic smh64_pkg::square_t square_of_signed_byte(logic [7:0] b);
        logic [8:0]  mag;
        logic [17:0] prod;
        mag  = b[7] ? (9'd256 - {1'b0, b}) : {1'b0, b};
        prod = mag * mag;
        return prod[smh64_pkg::SquareWidth-1:0];
    endfunction

    // Truncated signed remainder by the modulus; the sign follows the dividend.
    function automatic smh64_pkg::hash_t trunc_rem_by_modulus(smh64_pkg::hash_t v);
        smh64_pkg::hash_t modulus;
        smh64_pkg::hash_t mag;
        smh64_pkg::hash_t r;
        modulus = smh64_pkg::hash_t'(smh64_pkg::HashModulus);
        mag     = v[smh64_pkg::HashWidth-1] ? (~v + 1'b1) : v;
        r       = mag % modulus;
        return v[smh64_pkg::HashWidth-1] ? (~r + 1'b1) : r;
    endfunction

    // Fold one accepted byte into the predictor; a last byte yields a hash.
    function automatic void fold_byte_into_hash(logic [7:0] b, logic last);
        smh64_pkg::square_t sq;
        sq             = square_of_signed_byte(b);
        pred_sum       = pred_sum + smh64_pkg::hash_t'(sq);
        pred_remainder = trunc_rem_by_modulus((pred_remainder << smh64_pkg::HashShift)
                                              | smh64_pkg::hash_t'(sq));
        pred_parity    = pred_parity ^ sq;
        if (last)
        begin
            hash_expect.insert(hash_expect.size(),
                               (pred_remainder
                                | (smh64_pkg::hash_t'(pred_parity) << smh64_pkg::ParityShift))
                               + pred_sum);
            pred_remainder = '0;
            pred_sum       = '0;
            pred_parity    = '0;
        end
    endfunction

    function automatic int unsigned sender_idle_pct(link_phase_t ph);
        case (ph)
            PH_SENDER_GAPS: return 62;
            PH_BOTH_IDLE:   return 9;
            default:        return 0;
        endcase
    endfunction

    function automatic int unsigned receiver_stall_pct(link_phase_t ph);
        case (ph)
            PH_RECEIVER_STALLS: return 62;
            PH_BOTH_IDLE:       return 9;
            default:            return 0;
        endcase
    endfunction

    // Byte values weighted toward the signed extremes.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0:       return 8'h80;
            1:       return 8'h7f;
            2:       return 8'h81;
            3:       return 8'hff;
            4:       return 8'h00;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic push_byte(logic [7:0] data, logic last, link_phase_t ph);
        byte_req_t req;
        req.data  = data;
        req.last  = last;
        req.phase = ph;
        pending_bytes.insert(pending_bytes.size(), req);
        if (last)
            strings_queued++;
    endtask

    // Whole strings of random length until the chunk holds enough bytes.
    task automatic queue_random_strings(link_phase_t ph, int unsigned n_bytes);
        int unsigned queued;
        int unsigned len;
        queued = 0;
        while (queued < n_bytes)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(48, 13) : $urandom_range(8, 1);
            for (int unsigned i = 0; i < len; i++)
                push_byte(pick_byte(), i == len - 1, ph);
            queued += len;
        end
    endtask

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Reset is held for the first cycles of the run only.
    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Request driver: predicts on every accepted byte, then offers the next.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            byte_in    <= '0;
            is_last    <= 1'b0;
            link_phase <= PH_STEADY;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                fold_byte_into_hash(byte_in, is_last);
                bytes_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_bytes.size() != 0 &&
                    $urandom_range(99) >= sender_idle_pct(pending_bytes[0].phase))
                begin
                    next_req = pending_bytes.pop_front();
                    in_valid   <= 1'b1;
                    byte_in    <= next_req.data;
                    is_last    <= next_req.last;
                    link_phase <= next_req.phase;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // One long receiver hold-off during the first steady stretch, so the
    // block fills up and stalls its request side.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && link_phase == PH_STEADY && bytes_taken >= 60)
        begin
            hold_left <= HoldCycles;
            hold_done <= 1'b1;
        end
    end

    // Result monitor and receiver stall.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (hash_expect.size() == 0)
                begin
                    $error("unexpected hash_value %h with no string pending", hash_value);
                    mismatch_count++;
                end
                else
                begin
                    if (hash_value !== hash_expect[0])
                    begin
                        $error("hash_value mismatch: expected %h, actual %h",
                               hash_expect[0], hash_value);
                        mismatch_count++;
                    end
                    void'(hash_expect.pop_front());
                    hashes_checked++;
                end
            end
            out_stall <= (hold_left > 1) ||
                         ($urandom_range(99) < receiver_stall_pct(link_phase));
        end
    end

    // Stimulus: directed strings, then random strings phase by phase.
    initial
    begin
        pred_remainder = '0;
        pred_sum       = '0;
        pred_parity    = '0;
        bytes_taken    = 0;
        strings_queued = 0;
        hashes_checked = 0;
        mismatch_count = 0;

        // Single-byte strings at the signed extremes, zero byte included.
        push_byte(8'h00, 1'b1, PH_STEADY);
        push_byte(8'h01, 1'b1, PH_STEADY);
        push_byte(8'h7f, 1'b1, PH_STEADY);
        push_byte(8'h80, 1'b1, PH_STEADY);
        push_byte(8'h81, 1'b1, PH_STEADY);
        push_byte(8'hff, 1'b1, PH_STEADY);
        // Zero bytes inside a string do not end it.
        push_byte(8'h00, 1'b0, PH_STEADY);
        push_byte(8'h00, 1'b0, PH_STEADY);
        push_byte(8'h80, 1'b1, PH_STEADY);
        // Largest squares repeated push the shifted remainder above bit 55, into the fold.
        for (int i = 0; i < 10; i++)
            push_byte(8'h80, i == 9, PH_STEADY);
        // Mixed signs and alternating bit patterns.
        push_byte(8'h7f, 1'b0, PH_STEADY);
        push_byte(8'h00, 1'b0, PH_STEADY);
        push_byte(8'h81, 1'b0, PH_STEADY);
        push_byte(8'hff, 1'b0, PH_STEADY);
        push_byte(8'h55, 1'b0, PH_STEADY);
        push_byte(8'haa, 1'b1, PH_STEADY);

        queue_random_strings(PH_STEADY, 145);
        queue_random_strings(PH_SENDER_GAPS, 145);
        queue_random_strings(PH_RECEIVER_STALLS, 145);
        queue_random_strings(PH_BOTH_IDLE, 145);
        queue_random_strings(PH_STEADY, 145);

        // Drain: every request taken, every hash returned, then a short tail.
        @(posedge rst_n);
        while (pending_bytes.size() != 0 || in_valid || hashes_checked < strings_queued)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Covered %0d bytes in %0d strings, %0d hashes checked, long hold-off %s.",
                 bytes_taken, strings_queued, hashes_checked, hold_done ? "done" : "missed");
        $display("Phases: steady, sender gaps, receiver stalls, both idling, steady.");
        if (mismatch_count == 0 && hash_expect.size() == 0 &&
            hashes_checked == strings_queued)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #1ms;
        $display("status: fail");
        $finish;
    end

endmodule
